[rtl/branch_trace_message_encoder_macros.svh]
// Assertion macros used by the port-level trace encoder checker.
`ifndef BRANCH_TRACE_MESSAGE_ENCODER_MACROS_SVH
`define BRANCH_TRACE_MESSAGE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTME_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trace encoder check failed");

// Next-cycle implication, disabled during reset.
`define BTME_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trace encoder check failed");

`endif

[rtl/btme_pkg.sv]
// Types and constants of the branch trace message encoder.
`timescale 1ns / 1ps

package btme_pkg;

  localparam int CNT_W       = 17;
  localparam int MAX_RESULTS = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_CODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_TYPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT  = 3'd4;

  localparam logic [5:0] TC_DBR  = 6'd3;
  localparam logic [5:0] TC_IBR  = 6'd4;
  localparam logic [5:0] TC_SYNC = 6'd9;
  localparam logic [5:0] TC_CORR = 6'd33;

  localparam logic [1:0] MSEO_NONE  = 2'b00;
  localparam logic [1:0] MSEO_FIELD = 2'b01;
  localparam logic [1:0] MSEO_END   = 2'b11;

  localparam logic [1:0] KIND_BRANCH = 2'd1;
  localparam logic [1:0] KIND_JUMP   = 2'd2;

  localparam logic [3:0]  SYNC_CODE_RESET   = 4'd5;
  localparam logic [15:0] COUNT_LIMIT_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DATA,
    MODE_FULL
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_B1,
    S_FA,
    S_FB
  } state_t;

  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_B1,
    SEL_FA,
    SEL_FB
  } sel_t;

  typedef struct packed {
    logic load;
    logic emit;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic msg_start;
    logic has_b1;
    logic a_pres;
    logic rest_zero;
    logic done;
    logic out_free;
  } status_t;

endpackage

[rtl/btme_if.sv]
// Valid/ready channel interfaces for instructions in and trace bytes out.
`timescale 1ns / 1ps

interface btme_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] instr_addr;
  logic [1:0]  instr_kind;
  logic [1:0]  instr_size;

  modport source (output valid, output instr_addr, output instr_kind, output instr_size,
                  input ready);
  modport sink (input valid, input instr_addr, input instr_kind, input instr_size,
                output ready);
endinterface

interface btme_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] trace_byte;
  logic       last;

  modport source (output valid, output trace_byte, output last, input ready);
  modport sink (input valid, input trace_byte, input last, output ready);
endinterface

[rtl/btme_dp.sv]
// Datapath: trace state, message fields, chunk shifter and output register.
`timescale 1ns / 1ps

module btme_dp #(
  parameter int ADDR_WIDTH    = 64,
  parameter int MAX_MSG_BYTES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [btme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btme_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [63:0]                         in_addr,
  input  logic [1:0]                          in_kind,
  input  logic [1:0]                          in_size,
  input  logic                                out_ready,
  input  btme_pkg::cmd_t                      cmd,
  output btme_pkg::status_t                   status,
  output logic                                out_valid,
  output logic [7:0]                          out_byte,
  output logic                                out_last
);

  localparam int HW    = ADDR_WIDTH - 1;
  localparam int CW    = btme_pkg::CNT_W;
  localparam int VW    = (HW > CW) ? HW : CW;
  localparam int CAP   = (MAX_MSG_BYTES < btme_pkg::MAX_RESULTS) ?
                         MAX_MSG_BYTES : btme_pkg::MAX_RESULTS;
  localparam int IDX_W = $clog2(CAP);

  logic                trace_enable;
  logic [3:0]          event_code;
  logic [3:0]          sync_code;
  logic [1:0]          branch_type_code;
  logic [15:0]         count_limit;

  btme_pkg::mode_t     mode, mode_next;
  logic [CW-1:0]       instr_count, count_next;
  logic [1:0]          prev_kind;
  logic [HW-1:0]       last_half_addr;
  logic                lha_wr;

  logic [7:0]          hdr, hdr_next;
  logic [7:0]          b1, b1_next;
  logic [1:0]          b1_code, b1_code_next;
  logic                has_b1, has_b1_next;
  logic                a_pres, a_pres_next;
  logic [1:0]          a_code, a_code_next;
  logic                b_pres, b_pres_next;
  logic [VW-1:0]       sh, sh_next;
  logic [HW-1:0]       b_val, b_val_next;
  logic [IDX_W-1:0]    idx;

  logic [HW-1:0]       half;
  logic [CW-1:0]       cnt_add;
  logic                msg_start;
  logic [7:0]          byte_sel;
  logic                nat_end;
  logic                cap_hit;
  logic                rest_zero;
  logic                enable_rise;

  assign half        = in_addr[ADDR_WIDTH-1:1];
  assign cnt_add     = instr_count + CW'(in_size);
  assign rest_zero   = ~|sh[VW-1:6];
  assign cap_hit     = (idx == IDX_W'(CAP - 1));
  assign enable_rise = cfg_wr_en && (cfg_index == btme_pkg::CFG_TRACE_ENABLE) &&
                       !trace_enable && cfg_data[0];

  always_comb begin
    mode_next    = mode;
    count_next   = instr_count;
    lha_wr       = 1'b0;
    msg_start    = 1'b0;
    hdr_next     = {btme_pkg::TC_SYNC, btme_pkg::MSEO_NONE};
    b1_next      = {half[1:0], sync_code, btme_pkg::MSEO_NONE};
    b1_code_next = btme_pkg::MSEO_END;
    has_b1_next  = 1'b1;
    a_pres_next  = |half[HW-1:2];
    a_code_next  = btme_pkg::MSEO_END;
    b_pres_next  = 1'b0;
    sh_next      = VW'(half >> 2);
    b_val_next   = half ^ last_half_addr;
    if (trace_enable) begin
      unique case (mode)
        btme_pkg::MODE_IDLE: begin
          msg_start  = 1'b1;
          lha_wr     = 1'b1;
          count_next = cnt_add;
          mode_next  = btme_pkg::MODE_DATA;
        end
        btme_pkg::MODE_DATA: begin
          count_next = cnt_add;
          if (prev_kind == btme_pkg::KIND_BRANCH) begin
            msg_start   = 1'b1;
            hdr_next    = {btme_pkg::TC_DBR, btme_pkg::MSEO_NONE};
            has_b1_next = 1'b0;
            a_pres_next = 1'b1;
            sh_next     = VW'(instr_count);
            count_next  = CW'(in_size);
          end else if (prev_kind == btme_pkg::KIND_JUMP) begin
            msg_start    = 1'b1;
            lha_wr       = 1'b1;
            hdr_next     = {btme_pkg::TC_IBR, btme_pkg::MSEO_NONE};
            b1_next      = {instr_count[3:0], branch_type_code, btme_pkg::MSEO_NONE};
            b1_code_next = btme_pkg::MSEO_FIELD;
            a_pres_next  = |instr_count[CW-1:4];
            a_code_next  = btme_pkg::MSEO_FIELD;
            b_pres_next  = 1'b1;
            sh_next      = VW'(instr_count >> 4);
            count_next   = CW'(in_size);
          end
          mode_next = (count_next >= CW'(count_limit)) ? btme_pkg::MODE_FULL :
                      btme_pkg::MODE_DATA;
        end
        default: begin
          count_next = '0;
          mode_next  = btme_pkg::MODE_DATA;
        end
      endcase
    end else if (mode == btme_pkg::MODE_DATA) begin
      msg_start   = 1'b1;
      hdr_next    = {btme_pkg::TC_CORR, btme_pkg::MSEO_NONE};
      b1_next     = {instr_count[1:0], event_code, btme_pkg::MSEO_NONE};
      a_pres_next = |instr_count[CW-1:2];
      sh_next     = VW'(instr_count >> 2);
      count_next  = '0;
      mode_next   = btme_pkg::MODE_IDLE;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      btme_pkg::SEL_HDR: begin
        byte_sel = hdr;
        nat_end  = 1'b0;
      end
      btme_pkg::SEL_B1: begin
        byte_sel = b1 | {6'd0, a_pres ? btme_pkg::MSEO_NONE : b1_code};
        nat_end  = !a_pres && !b_pres;
      end
      btme_pkg::SEL_FA: begin
        byte_sel = {sh[5:0], rest_zero ? a_code : btme_pkg::MSEO_NONE};
        nat_end  = rest_zero && !b_pres;
      end
      default: begin
        byte_sel = {sh[5:0], rest_zero ? btme_pkg::MSEO_END : btme_pkg::MSEO_NONE};
        nat_end  = rest_zero;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable     <= 1'b0;
      event_code       <= '0;
      sync_code        <= btme_pkg::SYNC_CODE_RESET;
      branch_type_code <= '0;
      count_limit      <= btme_pkg::COUNT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        btme_pkg::CFG_TRACE_ENABLE: trace_enable     <= cfg_data[0];
        btme_pkg::CFG_EVENT_CODE:   event_code       <= cfg_data[3:0];
        btme_pkg::CFG_SYNC_CODE:    sync_code        <= cfg_data[3:0];
        btme_pkg::CFG_BRANCH_TYPE:  branch_type_code <= cfg_data[1:0];
        btme_pkg::CFG_COUNT_LIMIT:  count_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= btme_pkg::MODE_IDLE;
      instr_count <= '0;
      prev_kind   <= '0;
    end else begin
      if (enable_rise) begin
        mode <= btme_pkg::MODE_IDLE;
      end else if (cmd.load) begin
        mode <= mode_next;
      end
      if (cmd.load) begin
        instr_count <= count_next;
        prev_kind   <= in_kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && lha_wr) begin
      last_half_addr <= half;
    end
    if (cmd.load) begin
      hdr     <= hdr_next;
      b1      <= b1_next;
      b1_code <= b1_code_next;
      has_b1  <= has_b1_next;
      a_pres  <= a_pres_next;
      a_code  <= a_code_next;
      b_pres  <= b_pres_next;
      b_val   <= b_val_next;
      sh      <= sh_next;
      idx     <= '0;
    end else if (cmd.emit) begin
      idx <= idx + IDX_W'(1);
      if ((cmd.sel == btme_pkg::SEL_FA && rest_zero && b_pres) ||
          (cmd.sel == btme_pkg::SEL_B1 && !a_pres)) begin
        sh <= VW'(b_val);
      end else if (cmd.sel == btme_pkg::SEL_FA || cmd.sel == btme_pkg::SEL_FB) begin
        sh <= sh >> 6;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= cap_hit ? (byte_sel | {6'd0, btme_pkg::MSEO_END}) : byte_sel;
      out_last <= nat_end || cap_hit;
    end
  end

  assign status.msg_start = msg_start;
  assign status.has_b1    = has_b1;
  assign status.a_pres    = a_pres;
  assign status.rest_zero = rest_zero;
  assign status.done      = nat_end || cap_hit;
  assign status.out_free  = !out_valid || out_ready;

endmodule

[rtl/btme_ctrl.sv]
// Controller: accepts instructions and walks the fields of each message.
`timescale 1ns / 1ps

module btme_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  btme_pkg::status_t status,
  output btme_pkg::cmd_t    cmd
);

  btme_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btme_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btme_pkg::S_IDLE: begin
        if (in_valid && status.msg_start) begin
          state_next = btme_pkg::S_HDR;
        end
      end
      btme_pkg::S_HDR: begin
        if (status.out_free) begin
          priority if (status.done) state_next = btme_pkg::S_IDLE;
          else if (status.has_b1) state_next = btme_pkg::S_B1;
          else state_next = btme_pkg::S_FA;
        end
      end
      btme_pkg::S_B1: begin
        if (status.out_free) begin
          priority if (status.done) state_next = btme_pkg::S_IDLE;
          else if (status.a_pres) state_next = btme_pkg::S_FA;
          else state_next = btme_pkg::S_FB;
        end
      end
      btme_pkg::S_FA: begin
        if (status.out_free) begin
          priority if (status.done) state_next = btme_pkg::S_IDLE;
          else if (status.rest_zero) state_next = btme_pkg::S_FB;
          else state_next = btme_pkg::S_FA;
        end
      end
      btme_pkg::S_FB: begin
        if (status.out_free && status.done) begin
          state_next = btme_pkg::S_IDLE;
        end
      end
      default: state_next = btme_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.emit = 1'b0;
    cmd.sel  = btme_pkg::SEL_HDR;
    unique case (state)
      btme_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      btme_pkg::S_HDR: begin
        cmd.emit = status.out_free;
        cmd.sel  = btme_pkg::SEL_HDR;
      end
      btme_pkg::S_B1: begin
        cmd.emit = status.out_free;
        cmd.sel  = btme_pkg::SEL_B1;
      end
      btme_pkg::S_FA: begin
        cmd.emit = status.out_free;
        cmd.sel  = btme_pkg::SEL_FA;
      end
      btme_pkg::S_FB: begin
        cmd.emit = status.out_free;
        cmd.sel  = btme_pkg::SEL_FB;
      end
      default: ;
    endcase
  end

endmodule

[rtl/branch_trace_message_encoder.sv]
// Top level of the branch trace message encoder.
// The instr channel takes one committed instruction per transfer: address,
// kind and size. The trace channel gives the message bytes that the
// instruction causes, one byte per transfer, with last set on the final byte.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this. An instruction that causes no message
// leaves the controller idle. For one that causes a message, the fields
// are registered when it is taken; the field sequencer then loads the
// bytes into the output register in order, one 6-bit chunk a cycle while
// that register is free. A new instruction is taken in the cycle after
// the final byte is loaded, while it may still wait in the output register.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits. Reset puts the mode, count, previous kind and config
// registers at their reset values and empties the output register.
`timescale 1ns / 1ps

module branch_trace_message_encoder #(
  parameter int ADDR_WIDTH    = 64,
  parameter int MAX_MSG_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  btme_in_if.sink                         instr,
  btme_out_if.source                      trace,
  input  logic                            cfg_wr_en,
  input  logic [btme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btme_pkg::CFG_DATA_W-1:0] cfg_data
);

  btme_pkg::cmd_t    cmd;
  btme_pkg::status_t status;

  btme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (instr.valid),
    .in_ready (instr.ready),
    .status   (status),
    .cmd      (cmd)
  );

  btme_dp #(
    .ADDR_WIDTH    (ADDR_WIDTH),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_addr   (instr.instr_addr),
    .in_kind   (instr.instr_kind),
    .in_size   (instr.instr_size),
    .out_ready (trace.ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (trace.valid),
    .out_byte  (trace.trace_byte),
    .out_last  (trace.last)
  );

endmodule

[rtl/btme_checker.sv]
// Port-level checker for the branch trace message encoder, with its bind.
`timescale 1ns / 1ps
`include "branch_trace_message_encoder_macros.svh"

module btme_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  `BTME_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))
  `BTME_ASSERT_IMPL(a_last_ends_msg, clk, rst, out_valid && out_last, out_byte[1:0] == btme_pkg::MSEO_END)
  `BTME_ASSERT_IMPL(a_mid_not_end, clk, rst, out_valid && !out_last, out_byte[1:0] != btme_pkg::MSEO_END)
  `BTME_ASSERT_IMPL(a_busy_mid_msg, clk, rst, out_valid && !out_last, !in_ready)

endmodule

bind branch_trace_message_encoder btme_checker u_btme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (instr.valid),
  .in_ready  (instr.ready),
  .out_valid (trace.valid),
  .out_ready (trace.ready),
  .out_byte  (trace.trace_byte),
  .out_last  (trace.last)
);

[sim/branch_trace_message_encoder_checker.sv]
// Predicts and checks the trace bytes that the branch trace message encoder sends.
`timescale 1ns / 1ps

module branch_trace_message_encoder_checker #(
  parameter int ADDR_WIDTH    = 64,
  parameter int MAX_MSG_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  btme_in_if                              instr,
  btme_out_if                             trace,
  input  logic                            cfg_wr_en,
  input  logic [btme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btme_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    logic [7:0] tbyte;
    logic       last;
  } trace_beat_t;

  localparam int MSG_CAP = 48;
  localparam int CW      = btme_pkg::CNT_W;

  logic                enable_q;
  logic [3:0]          event_q;
  logic [3:0]          sync_q;
  logic [1:0]          btype_q;
  logic [15:0]         limit_q;
  btme_pkg::mode_t     mode_q;
  logic [CW-1:0]       count_q;
  logic [1:0]          prev_kind_q;
  logic [62:0]         half_q;
  trace_beat_t         expected_bytes[$];
  logic [7:0]          msg_buf[MSG_CAP];
  int                  msg_len;

  function automatic void emit_byte(logic [7:0] b);
    if (msg_len < MSG_CAP) begin
      msg_buf[msg_len] = b;
      msg_len++;
    end
  endfunction

  // Sends v six bits at a time, low chunk first; the final chunk carries code.
  function automatic void emit_chunks(logic [63:0] v, logic [1:0] code);
    logic [63:0] rest;
    do begin
      rest = v >> 6;
      emit_byte({v[5:0], (rest == 64'd0) ? code : btme_pkg::MSEO_NONE});
      v = rest;
    end while (v != 64'd0);
  endfunction

  function automatic void emit_coded(logic [5:0] tcode, logic [3:0] code4,
                                     logic [63:0] val);
    emit_byte({tcode, btme_pkg::MSEO_NONE});
    if (val < 64'd4) begin
      emit_byte({val[1:0], code4, btme_pkg::MSEO_END});
    end else begin
      emit_byte({val[1:0], code4, btme_pkg::MSEO_NONE});
      emit_chunks(val >> 2, btme_pkg::MSEO_END);
    end
  endfunction

  function automatic void emit_indirect(logic [CW-1:0] icnt, logic [63:0] uaddr);
    emit_byte({btme_pkg::TC_IBR, btme_pkg::MSEO_NONE});
    if (icnt < CW'(16)) begin
      emit_byte({icnt[3:0], btype_q, btme_pkg::MSEO_FIELD});
    end else begin
      emit_byte({icnt[3:0], btype_q, btme_pkg::MSEO_NONE});
      emit_chunks(64'(icnt >> 4), btme_pkg::MSEO_FIELD);
    end
    emit_chunks(uaddr, btme_pkg::MSEO_END);
  endfunction

  function automatic void apply_cfg_write(logic [btme_pkg::CFG_IDX_W-1:0] idx,
                                          logic [btme_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      btme_pkg::CFG_TRACE_ENABLE: begin
        if (!enable_q && val[0]) mode_q = btme_pkg::MODE_IDLE;
        enable_q = val[0];
      end
      btme_pkg::CFG_EVENT_CODE:  event_q = val[3:0];
      btme_pkg::CFG_SYNC_CODE:   sync_q = val[3:0];
      btme_pkg::CFG_BRANCH_TYPE: btype_q = val[1:0];
      btme_pkg::CFG_COUNT_LIMIT: limit_q = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic void encode_instr(logic [63:0] addr, logic [1:0] kind, logic [1:0] size);
    logic [63:0]      amask;
    logic [62:0]      half;
    logic [1:0]       pk;
    logic [CW-1:0]    old;
    int               k;
    amask = {64{1'b1}} >> (64 - ADDR_WIDTH);
    half = 63'((addr & amask) >> 1);
    pk = prev_kind_q;
    prev_kind_q = kind;
    msg_len = 0;
    if (enable_q) begin
      if (mode_q == btme_pkg::MODE_IDLE) begin
        emit_coded(btme_pkg::TC_SYNC, sync_q, {1'b0, half});
        half_q = half;
        count_q = count_q + CW'(size);
        mode_q = btme_pkg::MODE_DATA;
      end else if (mode_q == btme_pkg::MODE_DATA) begin
        old = count_q;
        count_q = count_q + CW'(size);
        if (pk == btme_pkg::KIND_BRANCH) begin
          emit_byte({btme_pkg::TC_DBR, btme_pkg::MSEO_NONE});
          emit_chunks(64'(old), btme_pkg::MSEO_END);
          count_q = CW'(size);
        end else if (pk == btme_pkg::KIND_JUMP) begin
          emit_indirect(old, {1'b0, half ^ half_q});
          half_q = half;
          count_q = CW'(size);
        end
        mode_q = (count_q >= {1'b0, limit_q}) ? btme_pkg::MODE_FULL : btme_pkg::MODE_DATA;
      end else begin
        mode_q = btme_pkg::MODE_DATA;
        count_q = '0;
      end
    end else if (mode_q == btme_pkg::MODE_DATA) begin
      emit_coded(btme_pkg::TC_CORR, event_q, 64'(count_q));
      mode_q = btme_pkg::MODE_IDLE;
      count_q = '0;
    end
    if (msg_len > MAX_MSG_BYTES) begin
      msg_len = MAX_MSG_BYTES;
      msg_buf[msg_len-1][1:0] = btme_pkg::MSEO_END;
    end
    for (k = 0; k < msg_len; k++) begin
      expected_bytes.push_back('{tbyte: msg_buf[k], last: (k == msg_len - 1)});
    end
  endfunction

  always @(posedge clk) begin : compare
    trace_beat_t beat;
    if (rst) begin
      enable_q = 1'b0;
      event_q = '0;
      sync_q = btme_pkg::SYNC_CODE_RESET;
      btype_q = '0;
      limit_q = btme_pkg::COUNT_LIMIT_RESET;
      mode_q = btme_pkg::MODE_IDLE;
      count_q = '0;
      prev_kind_q = '0;
      half_q = '0;
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) apply_cfg_write(cfg_index, cfg_data);
      if (trace.valid && trace.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected trace transfer: trace_byte %02h last %0b",
                 trace.trace_byte, trace.last);
          errors++;
        end else begin
          beat = expected_bytes.pop_front();
          if (trace.trace_byte !== beat.tbyte) begin
            $error("trace_byte: expected %02h, actual %02h", beat.tbyte, trace.trace_byte);
            errors++;
          end
          if (trace.last !== beat.last) begin
            $error("last: expected %0b, actual %0b", beat.last, trace.last);
            errors++;
          end
        end
      end
      if (instr.valid && instr.ready) begin
        encode_instr(instr.instr_addr, instr.instr_kind, instr.instr_size);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

[sim/branch_trace_message_encoder_tb.sv]
// Testbench top of the branch trace message encoder: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module branch_trace_message_encoder_tb;

  localparam int         QUIET_LIMIT  = 2000;
  localparam int         SYNC_REPEATS = 6;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 22;
  localparam logic [1:0] KIND_OTHER   = 2'd0;
  localparam logic [1:0] KIND_THREE   = 2'd3;
  localparam logic [1:0] KIND_BRANCH  = btme_pkg::KIND_BRANCH;
  localparam logic [1:0] KIND_JUMP    = btme_pkg::KIND_JUMP;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [btme_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [btme_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              errors;
  int                              pending;
  int                              quiet_cycles;
  bit                              calm;
  logic [63:0]                     last_addr;

  btme_in_if  instr ();
  btme_out_if trace ();

  branch_trace_message_encoder #(
    .ADDR_WIDTH   (64),
    .MAX_MSG_BYTES(16)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .instr    (instr),
    .trace    (trace),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  branch_trace_message_encoder_checker #(
    .ADDR_WIDTH   (64),
    .MAX_MSG_BYTES(16)
  ) trace_check (
    .clk      (clk),
    .rst      (rst),
    .instr    (instr),
    .trace    (trace),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    trace.ready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst || (instr.valid && instr.ready) || (trace.valid && trace.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("branch_trace_message_encoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [btme_pkg::CFG_IDX_W-1:0] idx,
                           logic [btme_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_instr(logic [63:0] addr, logic [1:0] kind, logic [1:0] size);
    while (!calm && $urandom_range(99) < 31) begin
      instr.valid <= 1'b0;
      @(negedge clk);
    end
    instr.valid <= 1'b1;
    instr.instr_addr <= addr;
    instr.instr_kind <= kind;
    instr.instr_size <= size;
    do @(posedge clk); while (!instr.ready);
    @(negedge clk);
    last_addr = addr;
  endtask

  task automatic settle(int extra);
    instr.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(4))
      0: pick_addr = {$urandom, $urandom};
      1: pick_addr = 64'($urandom_range(255));
      2: pick_addr = last_addr ^ (64'd1 << $urandom_range(63));
      3: pick_addr = last_addr + 64'(2 * $urandom_range(64));
      default: pick_addr = {32'hFFFF_FFFF, $urandom};
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 45) pick_kind = KIND_OTHER;
    else if (r < 65) pick_kind = KIND_BRANCH;
    else if (r < 88) pick_kind = KIND_JUMP;
    else pick_kind = KIND_THREE;
  endfunction

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    instr.valid = 1'b0;
    instr.instr_addr = '0;
    instr.instr_kind = '0;
    instr.instr_size = '0;
    calm = 1'b0;
    last_addr = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Tracing off from reset: nothing is sent.
    send_instr(64'h0, KIND_BRANCH, 2'd1);
    settle(4);
    write_reg(btme_pkg::CFG_EVENT_CODE, 16'd15);
    write_reg(btme_pkg::CFG_SYNC_CODE, 16'd0);
    write_reg(btme_pkg::CFG_BRANCH_TYPE, 16'd3);
    write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'hFFFF);
    write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd1);
    send_instr({64{1'b1}}, KIND_JUMP, 2'd3);
    send_instr(64'h0, KIND_BRANCH, 2'd0);
    send_instr(64'h2, KIND_THREE, 2'd3);
    send_instr(64'h5, KIND_JUMP, 2'd2);
    repeat (6) send_instr(64'h10, KIND_OTHER, 2'd3);
    send_instr(64'h1234_5678_9ABC_DEF0, KIND_JUMP, 2'd1);
    send_instr(64'h1234_5678_9ABC_DEF2, KIND_OTHER, 2'd0);
    repeat (3) send_instr(64'h40, KIND_OTHER, 2'd3);
    settle(4);
    write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd0);
    send_instr(64'h44, KIND_OTHER, 2'd1);
    send_instr(64'h48, KIND_BRANCH, 2'd1);
    settle(4);
    write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'd1);
    write_reg(btme_pkg::CFG_EVENT_CODE, 16'd0);
    write_reg(btme_pkg::CFG_SYNC_CODE, 16'd15);
    write_reg(btme_pkg::CFG_BRANCH_TYPE, 16'd0);
    write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd1);
    send_instr(64'h6, KIND_OTHER, 2'd1);
    send_instr(64'h8, KIND_OTHER, 2'd1);
    send_instr(64'h8, KIND_BRANCH, 2'd0);
    send_instr(64'h8, KIND_OTHER, 2'd0);
    settle(4);
    write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'd0);
    send_instr(64'h8, KIND_OTHER, 2'd0);
    send_instr(64'hA, KIND_OTHER, 2'd2);
    settle(4);
    write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd0);
    send_instr(64'hC, KIND_OTHER, 2'd1);
    settle(4);

    // Repeated restarts pile up the count through sync messages.
    calm = 1'b1;
    write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'hFFFF);
    for (int i = 0; i < SYNC_REPEATS; i++) begin
      write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd0);
      write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd1);
      send_instr(64'($urandom_range(7)), (i == SYNC_REPEATS - 1) ? KIND_JUMP : KIND_OTHER,
                 2'd3);
      settle(1);
    end
    send_instr(64'h1234, KIND_OTHER, 2'd1);
    calm = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      settle(4);
      calm = (p == 4 || p == 5);
      write_reg(btme_pkg::CFG_EVENT_CODE, 16'($urandom_range(15)));
      write_reg(btme_pkg::CFG_SYNC_CODE, 16'($urandom_range(15)));
      write_reg(btme_pkg::CFG_BRANCH_TYPE, 16'($urandom_range(3)));
      case ($urandom_range(3))
        0: write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'hFFFF);
        1: write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'($urandom_range(40, 1)));
        2: write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'($urandom_range(65535, 1)));
        default: write_reg(btme_pkg::CFG_COUNT_LIMIT, 16'($urandom_range(8, 1)));
      endcase
      case ($urandom_range(9))
        0, 1: write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd0);
        2, 3, 4: begin
          write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd0);
          write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd1);
        end
        default: write_reg(btme_pkg::CFG_TRACE_ENABLE, 16'd1);
      endcase
      repeat (PHASE_ITEMS) send_instr(pick_addr(), pick_kind(), 2'($urandom_range(3)));
    end

    settle(20);
    if (errors == 0) begin
      $display("branch_trace_message_encoder: match");
    end else begin
      $display("branch_trace_message_encoder: mismatch");
    end
    $finish;
  end

endmodule
